[hdl/mrbm_pkg.sv]
package mrbm_pkg;

	// Sizes
	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int CNT_W    = $clog2(MAX_COLS + 1);
	localparam int ROWC_W   = $clog2(MAX_ROWS + 1);
	localparam int HGT_W    = ROWC_W;
	localparam int AREA_W   = 13;
	localparam int PROD_W   = HGT_W + CNT_W;
	localparam int CFG_W    = 7;
	localparam logic [AREA_W-1:0] AREA_LIMIT = {AREA_W{1'b1}};

	// Register indexes
	typedef enum logic {
		CFG_COLUMN_COUNT = 1'b0,
		CFG_ROW_COUNT    = 1'b1
	} cfg_idx_t;

	// Sequencer steps
	typedef enum logic [2:0] {
		STEP_IDLE  = 3'd0,
		STEP_CELL  = 3'd1,
		STEP_FETCH = 3'd2,
		STEP_CUR   = 3'd3,
		STEP_TEST  = 3'd4,
		STEP_TOP   = 3'd5,
		STEP_PUSH  = 3'd6,
		STEP_ROW   = 3'd7
	} step_t;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_CELL,
		OP_FETCH,
		OP_CUR,
		OP_TEST,
		OP_TOP,
		OP_PUSH,
		OP_ROW
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_ACCEPT,
		C_ROW_ON,
		C_POP,
		C_SCAN_DONE,
		C_ROW_GO
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ucode_t;

	typedef struct packed {
		logic [HGT_W-1:0] hgt;
		logic [CNT_W-1:0] start;
	} stk_ent_t;

	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] waddr;
		logic [HGT_W-1:0] wdata;
		logic [COL_W-1:0] raddr;
		logic             clr;
	} hmem_ctl_t;

	// Control store: one word per step
	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		unique case (s)
			STEP_IDLE:  w = '{OP_IDLE,  C_ACCEPT,    STEP_CELL,  STEP_IDLE};
			STEP_CELL:  w = '{OP_CELL,  C_ROW_ON,    STEP_IDLE,  STEP_FETCH};
			STEP_FETCH: w = '{OP_FETCH, C_ALWAYS,    STEP_CUR,   STEP_CUR};
			STEP_CUR:   w = '{OP_CUR,   C_ALWAYS,    STEP_TEST,  STEP_TEST};
			STEP_TEST:  w = '{OP_TEST,  C_POP,       STEP_TOP,   STEP_PUSH};
			STEP_TOP:   w = '{OP_TOP,   C_ALWAYS,    STEP_TEST,  STEP_TEST};
			STEP_PUSH:  w = '{OP_PUSH,  C_SCAN_DONE, STEP_ROW,   STEP_FETCH};
			STEP_ROW:   w = '{OP_ROW,   C_ROW_GO,    STEP_IDLE,  STEP_ROW};
		endcase
		return w;
	endfunction

	// Zero reads as one, large values saturate
	function automatic logic [CNT_W-1:0] clamp_count(logic [CFG_W-1:0] v,
			logic [CNT_W-1:0] limit);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (CNT_W'(v) > limit) begin
			r = limit;
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage

[hdl/mrbm_cell_if.sv]
interface mrbm_cell_if;
	logic valid;
	logic ready;
	logic cell_req;

	modport source (output valid, output cell_req, input ready);
	modport sink (input valid, input cell_req, output ready);
endinterface

[hdl/mrbm_area_if.sv]
interface mrbm_area_if import mrbm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] max_area;

	modport source (output valid, output max_area, input ready);
	modport sink (input valid, input max_area, output ready);
endinterface

[hdl/maximal_rectangle_binary_matrix.sv]
// Flow: a cell is taken in the idle step and written in the cell step; at row end a
// histogram scan runs fetch, current, test and push steps for each column and for the
// zero sentinel, a top step for each stack pop and one closing row step.
// No cell is taken during the scan; the last row's closing step waits until the result register is free.
// Rate is set by the registered height-memory read and the one-entry-per-step stack.
// Reset: counts go to 64, heights, positions, best area and stack clear at once.
module maximal_rectangle_binary_matrix import mrbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	mrbm_cell_if.sink        cells,
	mrbm_area_if.source      result
);

	step_t             pc_q, pc_nxt;
	ucode_t            ucw;
	logic              cond_ok;

	logic [CNT_W-1:0]  col_cnt_q;
	logic [ROWC_W-1:0] row_cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROWC_W-1:0] row_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  d_q;
	logic [CNT_W-1:0]  start_q;
	logic [HGT_W-1:0]  cur_q;
	stk_ent_t          top_q;
	logic [PROD_W-1:0] prod_q;
	logic [AREA_W-1:0] best_q;
	logic              cell_q;
	logic              out_vld_q;
	logic [AREA_W-1:0] out_area_q;

	stk_ent_t          stk [MAX_COLS];
	stk_ent_t          stk_rd_q;
	logic [COL_W-1:0]  stk_raddr;
	logic              stk_we;

	hmem_ctl_t         hctl;
	logic [HGT_W-1:0]  hrd;

	logic              accept;
	logic [CNT_W-1:0]  col_nxt;
	logic [ROWC_W-1:0] row_nxt;
	logic              pop;
	logic              out_free;
	logic              matrix_end;
	logic [HGT_W-1:0]  new_hgt;
	logic [AREA_W-1:0] area;

	assign ucw = ucode_rom(pc_q);

	// Shared conditions
	assign accept     = cells.valid && cells.ready;
	assign col_nxt    = CNT_W'(col_q) + CNT_W'(1);
	assign row_nxt    = row_q + ROWC_W'(1);
	assign pop        = (d_q != '0) && (top_q.hgt >= cur_q);
	assign out_free   = !out_vld_q || result.ready;
	assign matrix_end = (ucw.op == OP_ROW) && (row_nxt >= row_cnt_q) && out_free;
	assign area       = (prod_q > PROD_W'(AREA_LIMIT)) ? AREA_LIMIT : prod_q[AREA_W-1:0];

	// Cell update: grow to the row count, zero on a clear cell
	always_comb begin
		if (!cell_q) begin
			new_hgt = '0;
		end else if (hrd < row_cnt_q) begin
			new_hgt = hrd + HGT_W'(1);
		end else begin
			new_hgt = row_cnt_q;
		end
	end

	// Next step
	always_comb begin
		unique case (ucw.cond)
			C_ALWAYS:    cond_ok = 1'b1;
			C_ACCEPT:    cond_ok = accept;
			C_ROW_ON:    cond_ok = col_nxt < col_cnt_q;
			C_POP:       cond_ok = pop;
			C_SCAN_DONE: cond_ok = i_q == col_cnt_q;
			C_ROW_GO:    cond_ok = (row_nxt < row_cnt_q) || out_free;
			default:     cond_ok = 1'b1;
		endcase
		pc_nxt = cond_ok ? ucw.tgt_t : ucw.tgt_f;
	end

	// Control word decode
	always_comb begin
		cells.ready = ucw.op == OP_IDLE;
		hctl.we     = ucw.op == OP_CELL;
		hctl.waddr  = col_q;
		hctl.wdata  = new_hgt;
		hctl.raddr  = (ucw.op == OP_FETCH) ? i_q[COL_W-1:0] : col_q;
		hctl.clr    = matrix_end;
		stk_we      = (ucw.op == OP_PUSH) && (i_q < col_cnt_q) && (d_q != '0);
		stk_raddr   = COL_W'(d_q - CNT_W'(2));
	end

	mrbm_hgt_mem u_hgt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hctl),
		.rdata  (hrd)
	);

	// Index stack below the top entry
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk[COL_W'(d_q - CNT_W'(1))] <= top_q;
		end
		stk_rd_q <= stk[stk_raddr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_q <= cells.cell_req;
		end
		unique case (ucw.op)
			OP_FETCH: start_q <= i_q;
			OP_CUR:   cur_q <= (i_q < col_cnt_q) ? hrd : '0;
			OP_TEST: begin
				if (pop) begin
					prod_q  <= PROD_W'(top_q.hgt) * PROD_W'(i_q - top_q.start);
					start_q <= top_q.start;
				end
			end
			OP_TOP: begin
				if (d_q != '0) begin
					top_q <= stk_rd_q;
				end
			end
			OP_PUSH: begin
				if (i_q < col_cnt_q) begin
					top_q <= '{hgt: cur_q, start: start_q};
				end
			end
			default: ;
		endcase
		if (matrix_end) begin
			out_area_q <= best_q;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= STEP_IDLE;
			col_cnt_q <= CNT_W'(MAX_COLS);
			row_cnt_q <= ROWC_W'(MAX_ROWS);
			col_q     <= '0;
			row_q     <= '0;
			i_q       <= '0;
			d_q       <= '0;
			best_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			pc_q <= pc_nxt;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_idx))
					CFG_COLUMN_COUNT: col_cnt_q <= clamp_count(cfg_data, CNT_W'(MAX_COLS));
					CFG_ROW_COUNT:    row_cnt_q <= clamp_count(cfg_data, ROWC_W'(MAX_ROWS));
				endcase
			end
			// result word: a new one replaces the one taken this cycle
			if (matrix_end) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (ucw.op)
				OP_CELL: begin
					if (col_nxt < col_cnt_q) begin
						col_q <= col_nxt[COL_W-1:0];
					end else begin
						col_q <= '0;
						i_q   <= '0;
						d_q   <= '0;
					end
				end
				OP_TEST: begin
					if (pop) begin
						d_q <= d_q - CNT_W'(1);
					end
				end
				OP_TOP: begin
					if (area > best_q) begin
						best_q <= area;
					end
				end
				OP_PUSH: begin
					i_q <= i_q + CNT_W'(1);
					if (i_q < col_cnt_q) begin
						d_q <= d_q + CNT_W'(1);
					end
				end
				OP_ROW: begin
					if (row_nxt < row_cnt_q) begin
						row_q <= row_nxt;
					end else if (out_free) begin
						row_q  <= '0;
						best_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign result.valid    = out_vld_q;
	assign result.max_area = out_area_q;

	// Checks
	a_stk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		d_q <= CNT_W'(MAX_COLS))
		else $error("stack depth past column limit");

	// the scan index ends one past the sentinel
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= CNT_W'(MAX_COLS + 1))
		else $error("scan index past column limit");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_IDLE) |-> (d_q == '0))
		else $error("stack not empty between rows");

	a_accept_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (pc_q == STEP_CELL))
		else $error("accepted word not processed");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(pc_q) == STEP_ROW))
		else $error("result word raised outside matrix end");

endmodule

[hdl/mrbm_hgt_mem.sv]
module mrbm_hgt_mem import mrbm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  hmem_ctl_t        ctl,
	output logic [HGT_W-1:0] rdata
);

	logic [HGT_W-1:0]    mem [MAX_COLS];
	logic [MAX_COLS-1:0] vld_q;
	logic [HGT_W-1:0]    rdata_q;
	logic                rvld_q;

	// Storage, registered read
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata_q <= mem[ctl.raddr];
	end

	// Per-column valid bits; a column never written since the clear reads zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[ctl.raddr];
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.we) begin
				vld_q[ctl.waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule
